FILE: rtl/gcsf_pkg.sv
// ----------------------------------------------------------------------------
// gcsf_pkg
// Types, constants and codes shared by the grid cell smoothing filter.
// ----------------------------------------------------------------------------
package gcsf_pkg;

    localparam int MAX_CELLS_DEF = 4096;

    // index arithmetic: row * width + col fits in 20 bits
    localparam int IDX_W = 20;
    localparam int REM_W = 37;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [23:0] HMAX = 24'hFFFFFF;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_ADJUST = 3'd1;
    localparam logic [2:0] OP_SMOOTH = 3'd2;
    localparam logic [2:0] OP_MARK   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RGB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_RGB   = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] col;
        logic [11:0] row;
        logic [23:0] height_in;
        logic [15:0] impact;
    } in_item_t;

    typedef struct packed {
        logic [23:0] height_out;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        status;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  grid_width;
        logic [12:0] cell_count;
        logic [15:0] max_height;
        logic [23:0] base_rgb;
        logic [23:0] peak_rgb;
    } cfg_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_MAC_HI,
        ALU_DIV_LOAD,
        ALU_DIV_STEP
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [23:0]      a;
        logic [23:0]      b;
        logic [REM_W-1:0] rem_ld;
        logic [63:0]      num_ld;
        logic [REM_W-1:0] den;
    } alu_req_t;

    typedef struct packed {
        logic [63:0]      acc;
        logic [63:0]      quo;
        logic [REM_W-1:0] rem;
    } alu_rsp_t;

endpackage

FILE: rtl/gcsf_if.sv
// ----------------------------------------------------------------------------
// gcsf channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface gcsf_in_if;
    logic               valid;
    logic               ready;
    gcsf_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gcsf_out_if;
    logic                valid;
    logic                ready;
    gcsf_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/gcsf_alu.sv
// ----------------------------------------------------------------------------
// gcsf_alu
// Shared 24x24 multiplier with accumulator and a restoring divider step.
// ----------------------------------------------------------------------------
module gcsf_alu
(
    input  logic                clk,
    input  gcsf_pkg::alu_req_t  req,
    output gcsf_pkg::alu_rsp_t  rsp
);

    logic [63:0]                acc_reg;
    logic [63:0]                quo_reg;
    logic [gcsf_pkg::REM_W-1:0] rem_reg;
    logic [gcsf_pkg::REM_W-1:0] den_reg;
    logic [47:0]                prod;
    logic [gcsf_pkg::REM_W-1:0] trial;

    assign prod  = req.a * req.b;
    assign trial = {rem_reg[gcsf_pkg::REM_W-2:0], quo_reg[63]};

    always_ff @(posedge clk)
    begin
        case (req.op)
            gcsf_pkg::ALU_MUL:
            begin
                acc_reg <= {16'b0, prod};
            end
            gcsf_pkg::ALU_MAC_HI:
            begin
                acc_reg <= acc_reg + {prod[39:0], 24'b0};
            end
            gcsf_pkg::ALU_DIV_LOAD:
            begin
                rem_reg <= req.rem_ld;
                quo_reg <= req.num_ld;
                den_reg <= req.den;
            end
            gcsf_pkg::ALU_DIV_STEP:
            begin
                if (trial >= den_reg)
                begin
                    rem_reg <= trial - den_reg;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.acc = acc_reg;
    assign rsp.quo = quo_reg;
    assign rsp.rem = rem_reg;

endmodule

FILE: rtl/gcsf_store.sv
// ----------------------------------------------------------------------------
// gcsf_store
// Height and river memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gcsf_store
#(
    parameter int MAX_CELLS = gcsf_pkg::MAX_CELLS_DEF,
    parameter int AW        = $clog2(MAX_CELLS)
)
(
    input  logic          clk,
    input  logic          h_we,
    input  logic          r_we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   h_wdata,
    input  logic          r_wdata,
    input  logic [AW-1:0] raddr,
    output logic [23:0]   h_rdata,
    output logic          r_rdata
);

    logic [23:0] h_mem [MAX_CELLS];
    logic        r_mem [MAX_CELLS];
    logic [23:0] h_rdata_reg;
    logic        r_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            h_mem[waddr] <= h_wdata;
        end
        if (r_we)
        begin
            r_mem[waddr] <= r_wdata;
        end
        h_rdata_reg <= h_mem[raddr];
        r_rdata_reg <= r_mem[raddr];
    end

    assign h_rdata = h_rdata_reg;
    assign r_rdata = r_rdata_reg;

endmodule

FILE: rtl/gcsf_ctrl.sv
// ----------------------------------------------------------------------------
// gcsf_ctrl
// Sequencer: index check, store access, adjust, smooth, colour blend.
// ----------------------------------------------------------------------------
module gcsf_ctrl
#(
    parameter int MAX_CELLS = gcsf_pkg::MAX_CELLS_DEF,
    parameter int AW        = $clog2(MAX_CELLS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  gcsf_pkg::cfg_t     cfg,
    gcsf_in_if.sink            in_ch,
    gcsf_out_if.source         out_ch,
    output gcsf_pkg::alu_req_t alu_req,
    input  gcsf_pkg::alu_rsp_t alu_rsp,
    output logic               h_we,
    output logic               r_we,
    output logic [AW-1:0]      waddr,
    output logic [23:0]        h_wdata,
    output logic               r_wdata,
    output logic [AW-1:0]      raddr,
    input  logic [23:0]        h_rdata,
    input  logic               r_rdata
);

    localparam int IW = gcsf_pkg::IDX_W;
    localparam logic [IW-1:0] CELLS = IW'(MAX_CELLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_IDX, S_CHK, S_RD, S_WR, S_COL,
        S_ADJ_M1, S_ADJ_M2, S_ADJ_M3, S_ADJ_DL, S_ADJ_FIN,
        S_SM_RD, S_SM_SUM, S_SM_DL, S_SM_FIN,
        S_BL_M, S_BL_DL, S_BL_FIN,
        S_DIV, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [2:0]          op_reg, op_next;
    logic [11:0]         col_reg, col_next;
    logic [11:0]         row_reg, row_next;
    logic [23:0]         hin_reg, hin_next;
    logic [15:0]         imp_reg, imp_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [23:0]         h_reg, h_next;
    logic                river_reg, river_next;
    logic [23:0]         diff_reg, diff_next;
    logic                up_reg, up_next;
    logic [23:0]         p1hi_reg, p1hi_next;
    logic [27:0]         sum_reg, sum_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [1:0]          dx_reg, dx_next;
    logic [1:0]          dy_reg, dy_next;
    logic                nbv_reg, nbv_next;
    logic [6:0]          dcnt_reg, dcnt_next;
    logic [1:0]          comp_reg, comp_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          blue_reg, blue_next;
    logic                err_reg, err_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                ov_reg, ov_next;
    gcsf_pkg::out_item_t od_reg, od_next;

    logic [6:0]          w;
    logic [IW-1:0]       lim;
    logic [22:0]         hq;
    logic [23:0]         mq;
    logic [IW-1:0]       idx_calc;
    logic                vx, vy, nb_ok;
    logic [12:0]         nx;
    logic signed [IW:0]  ti;
    logic signed [IW:0]  yoff;
    logic [7:0]          lo, hi, mag, v;
    logic                dneg;
    logic [8:0]          s9, c9;
    logic [31:0]         p;
    logic [23:0]         hsel;

    always_comb
    begin
        w   = (cfg.grid_width == 7'd0) ? 7'd1 : cfg.grid_width;
        lim = (IW'(cfg.cell_count) > CELLS) ? CELLS : IW'(cfg.cell_count);
        hq  = (cfg.max_height[15:1] == 15'd0) ? {15'd1, 8'd0} : {cfg.max_height[15:1], 8'd0};
        mq  = (cfg.max_height == 16'd0) ? {16'd1, 8'd0} : {cfg.max_height, 8'd0};
        idx_calc = IW'(row_reg) * IW'(w) + IW'(col_reg);

        // neighbour position for the current offset pair
        nx   = {1'b0, col_reg} + {11'b0, dx_reg} - 13'd1;
        vx   = !(dx_reg == 2'd0 && col_reg == 12'd0) && (nx < {6'b0, w});
        vy   = !(dy_reg == 2'd0 && row_reg == 12'd0);
        yoff = (dy_reg == 2'd0) ? -$signed({14'b0, w}) :
               (dy_reg == 2'd2) ? $signed({14'b0, w}) : '0;
        ti   = $signed({1'b0, idx_reg}) + yoff + $signed({{(IW-1){1'b0}}, dx_reg})
               - $signed((IW+1)'(1));
        nb_ok = vx && vy && (ti[IW-1:0] < lim);

        case (comp_reg)
            2'd0:    begin lo = cfg.base_rgb[23:16]; hi = cfg.peak_rgb[23:16]; end
            2'd1:    begin lo = cfg.base_rgb[15:8];  hi = cfg.peak_rgb[15:8];  end
            default: begin lo = cfg.base_rgb[7:0];   hi = cfg.peak_rgb[7:0];   end
        endcase
        dneg = hi < lo;
        mag  = dneg ? lo - hi : hi - lo;
        p    = alu_rsp.acc[31:0];
        s9   = {1'b0, lo} + {1'b0, alu_rsp.quo[7:0]};
        c9   = {1'b0, alu_rsp.quo[7:0]} + {8'b0, (alu_rsp.rem != '0)};
        if (dneg)
        begin
            v = ({1'b0, lo} > c9) ? lo - c9[7:0] : 8'd0;
        end
        else
        begin
            v = s9[8] ? 8'd255 : s9[7:0];
        end
        hsel = h_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        op_next    = op_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        hin_next   = hin_reg;
        imp_next   = imp_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        river_next = river_reg;
        diff_next  = diff_reg;
        up_next    = up_reg;
        p1hi_next  = p1hi_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        nbv_next   = nbv_reg;
        dcnt_next  = dcnt_reg;
        comp_next  = comp_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        err_next   = err_reg;
        clr_next   = clr_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;

        alu_req    = '0;
        alu_req.op = gcsf_pkg::ALU_NOP;
        h_we       = 1'b0;
        r_we       = 1'b0;
        waddr      = idx_reg[AW-1:0];
        h_wdata    = h_reg;
        r_wdata    = 1'b1;
        raddr      = (state_reg == S_SM_RD) ? ti[AW-1:0] : idx_reg[AW-1:0];

        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                h_we    = 1'b1;
                r_we    = 1'b1;
                waddr   = clr_reg;
                h_wdata = 24'd0;
                r_wdata = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next    = in_ch.data.op;
                    col_next   = in_ch.data.col;
                    row_next   = in_ch.data.row;
                    hin_next   = in_ch.data.height_in;
                    imp_next   = in_ch.data.impact;
                    state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                idx_next   = idx_calc;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (idx_reg >= lim)
                begin
                    err_next   = 1'b1;
                    h_next     = 24'd0;
                    red_next   = 8'd0;
                    green_next = 8'd0;
                    blue_next  = 8'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    err_next   = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                h_next     = h_rdata;
                river_next = r_rdata;
                up_next    = hin_reg >= {1'b0, hq};
                diff_next  = (hin_reg >= {1'b0, hq}) ? hin_reg - {1'b0, hq} : {1'b0, hq} - hin_reg;
                sum_next   = '0;
                cnt_next   = '0;
                dx_next    = '0;
                dy_next    = '0;
                nbv_next   = 1'b0;
                case (op_reg)
                    gcsf_pkg::OP_SET:
                    begin
                        h_next     = hin_reg;
                        state_next = S_WR;
                    end
                    gcsf_pkg::OP_ADJUST: state_next = S_ADJ_M1;
                    gcsf_pkg::OP_SMOOTH: state_next = S_SM_RD;
                    gcsf_pkg::OP_MARK:
                    begin
                        r_we       = 1'b1;
                        river_next = 1'b1;
                        state_next = S_COL;
                    end
                    default: state_next = S_COL;
                endcase
            end
            S_WR:
            begin
                h_we       = 1'b1;
                state_next = S_COL;
            end
            S_COL:
            begin
                comp_next = 2'd0;
                if (river_reg)
                begin
                    red_next   = 8'd0;
                    green_next = 8'd0;
                    blue_next  = 8'd255;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_BL_M;
                end
            end
            S_ADJ_M1:
            begin
                alu_req.op = gcsf_pkg::ALU_MUL;
                alu_req.a  = h_reg;
                alu_req.b  = diff_reg;
                state_next = S_ADJ_M2;
            end
            S_ADJ_M2:
            begin
                alu_req.op = gcsf_pkg::ALU_MUL;
                alu_req.a  = alu_rsp.acc[23:0];
                alu_req.b  = {8'b0, imp_reg};
                p1hi_next  = alu_rsp.acc[47:24];
                state_next = S_ADJ_M3;
            end
            S_ADJ_M3:
            begin
                alu_req.op = gcsf_pkg::ALU_MAC_HI;
                alu_req.a  = p1hi_reg;
                alu_req.b  = {8'b0, imp_reg};
                state_next = S_ADJ_DL;
            end
            S_ADJ_DL:
            begin
                alu_req.op     = gcsf_pkg::ALU_DIV_LOAD;
                alu_req.rem_ld = '0;
                alu_req.num_ld = alu_rsp.acc;
                alu_req.den    = {2'b0, hq, 12'b0};
                dcnt_next      = 7'd64;
                ret_next       = S_ADJ_FIN;
                state_next     = S_DIV;
            end
            S_ADJ_FIN:
            begin
                if (up_reg)
                begin
                    h_next = (alu_rsp.quo > {40'b0, gcsf_pkg::HMAX - h_reg}) ?
                             gcsf_pkg::HMAX : h_reg + alu_rsp.quo[23:0];
                end
                else
                begin
                    h_next = (alu_rsp.quo > {40'b0, h_reg}) ? 24'd0 : h_reg - alu_rsp.quo[23:0];
                end
                state_next = S_WR;
            end
            S_SM_RD:
            begin
                nbv_next = nb_ok;
                if (nbv_reg)
                begin
                    sum_next = sum_reg + {4'b0, h_rdata};
                    cnt_next = cnt_reg + 4'd1;
                end
                if (dy_reg == 2'd2)
                begin
                    dy_next = 2'd0;
                    dx_next = dx_reg + 2'd1;
                    if (dx_reg == 2'd2)
                    begin
                        state_next = S_SM_SUM;
                    end
                end
                else
                begin
                    dy_next = dy_reg + 2'd1;
                end
            end
            S_SM_SUM:
            begin
                if (nbv_reg)
                begin
                    sum_next = sum_reg + {4'b0, h_rdata};
                    cnt_next = cnt_reg + 4'd1;
                end
                state_next = S_SM_DL;
            end
            S_SM_DL:
            begin
                if (cnt_reg == 4'd0)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    alu_req.op     = gcsf_pkg::ALU_DIV_LOAD;
                    alu_req.rem_ld = '0;
                    alu_req.num_ld = {sum_reg, 36'b0};
                    alu_req.den    = {33'b0, cnt_reg};
                    dcnt_next      = 7'd28;
                    ret_next       = S_SM_FIN;
                    state_next     = S_DIV;
                end
            end
            S_SM_FIN:
            begin
                h_next     = alu_rsp.quo[23:0];
                state_next = S_WR;
            end
            S_BL_M:
            begin
                alu_req.op = gcsf_pkg::ALU_MUL;
                alu_req.a  = {16'b0, mag};
                alu_req.b  = hsel;
                state_next = S_BL_DL;
            end
            S_BL_DL:
            begin
                if (p[31:8] >= mq)
                begin
                    // quotient of 256 or more clamps either way
                    case (comp_reg)
                        2'd0:    red_next   = dneg ? 8'd0 : 8'd255;
                        2'd1:    green_next = dneg ? 8'd0 : 8'd255;
                        default: blue_next  = dneg ? 8'd0 : 8'd255;
                    endcase
                    comp_next  = comp_reg + 2'd1;
                    state_next = (comp_reg == 2'd2) ? S_DONE : S_BL_M;
                end
                else
                begin
                    alu_req.op     = gcsf_pkg::ALU_DIV_LOAD;
                    alu_req.rem_ld = {13'b0, p[31:8]};
                    alu_req.num_ld = {p[7:0], 56'b0};
                    alu_req.den    = {13'b0, mq};
                    dcnt_next      = 7'd8;
                    ret_next       = S_BL_FIN;
                    state_next     = S_DIV;
                end
            end
            S_BL_FIN:
            begin
                case (comp_reg)
                    2'd0:    red_next   = v;
                    2'd1:    green_next = v;
                    default: blue_next  = v;
                endcase
                comp_next  = comp_reg + 2'd1;
                state_next = (comp_reg == 2'd2) ? S_DONE : S_BL_M;
            end
            S_DIV:
            begin
                alu_req.op = gcsf_pkg::ALU_DIV_STEP;
                dcnt_next  = dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1)
                begin
                    state_next = ret_reg;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next            = 1'b1;
                    od_next.height_out = h_reg;
                    od_next.red        = red_reg;
                    od_next.green      = green_reg;
                    od_next.blue       = blue_reg;
                    od_next.status     = err_reg;
                    state_next         = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_IDLE;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        hin_reg   <= hin_next;
        imp_reg   <= imp_next;
        idx_reg   <= idx_next;
        h_reg     <= h_next;
        river_reg <= river_next;
        diff_reg  <= diff_next;
        up_reg    <= up_next;
        p1hi_reg  <= p1hi_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        nbv_reg   <= nbv_next;
        comp_reg  <= comp_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        err_reg   <= err_next;
        od_reg    <= od_next;
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

endmodule

FILE: rtl/grid_cell_smoothing_filter_core.sv
// ----------------------------------------------------------------------------
// grid_cell_smoothing_filter_core
// Cell height grid with set, adjust, 3x3 smooth, river mark and read.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores to zero, one cell a cycle, through
// all MAX_CELLS cells, and takes no request beat until the sweep is done. One
// request is worked at a time by a sequencer around one shared multiplier and
// a one-bit-a-cycle restoring divider, and one result beat follows each
// request. An out-of-range cell goes straight to its error result; a mark, or
// a read of a river cell, skips the colour blend; a read of any other cell
// runs three colour divides of 8 steps each, none for a clamped component;
// set writes the height back; adjust adds a 64-step divide before the write;
// smooth adds nine store reads through the single read port and a 28-step
// divide, none when no neighbour counts, then the write. A result beat still
// waiting on the receiver holds the sequencer in its last cycle.
module grid_cell_smoothing_filter_core
#(
    parameter int MAX_CELLS = gcsf_pkg::MAX_CELLS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    gcsf_in_if.sink                         in_ch,
    gcsf_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [gcsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcsf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_CELLS);

    gcsf_pkg::cfg_t     cfg_reg;
    gcsf_pkg::alu_req_t alu_req;
    gcsf_pkg::alu_rsp_t alu_rsp;
    logic               h_we, r_we, r_wdata, r_rdata;
    logic [AW-1:0]      waddr, raddr;
    logic [23:0]        h_wdata, h_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width <= 7'd64;
            cfg_reg.cell_count <= 13'd4096;
            cfg_reg.max_height <= 16'd255;
            cfg_reg.base_rgb   <= 24'd0;
            cfg_reg.peak_rgb   <= 24'hFFFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcsf_pkg::REG_GRID_WIDTH: cfg_reg.grid_width <= cfg_data[6:0];
                gcsf_pkg::REG_CELL_COUNT: cfg_reg.cell_count <= cfg_data[12:0];
                gcsf_pkg::REG_MAX_HEIGHT: cfg_reg.max_height <= cfg_data[15:0];
                gcsf_pkg::REG_BASE_RGB:   cfg_reg.base_rgb   <= cfg_data;
                gcsf_pkg::REG_PEAK_RGB:   cfg_reg.peak_rgb   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gcsf_ctrl #(.MAX_CELLS(MAX_CELLS), .AW(AW)) u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp),
        .h_we    (h_we),
        .r_we    (r_we),
        .waddr   (waddr),
        .h_wdata (h_wdata),
        .r_wdata (r_wdata),
        .raddr   (raddr),
        .h_rdata (h_rdata),
        .r_rdata (r_rdata)
    );

    gcsf_alu u_alu
    (
        .clk (clk),
        .req (alu_req),
        .rsp (alu_rsp)
    );

    gcsf_store #(.MAX_CELLS(MAX_CELLS), .AW(AW)) u_store
    (
        .clk     (clk),
        .h_we    (h_we),
        .r_we    (r_we),
        .waddr   (waddr),
        .h_wdata (h_wdata),
        .r_wdata (r_wdata),
        .raddr   (raddr),
        .h_rdata (h_rdata),
        .r_rdata (r_rdata)
    );

    // a request beat keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("ready high right after an accepted beat");

    // an error result carries no height and no colour
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.status |-> out_ch.data.height_out == 24'd0 &&
        out_ch.data.red == 8'd0 && out_ch.data.green == 8'd0 && out_ch.data.blue == 8'd0)
        else $error("error result with nonzero payload");

    // right after reset no result beat is valid and no request beat is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_ch.valid && !in_ch.ready)
        else $error("activity right after reset");

endmodule
